FILE: rtl/xbr_pkg.sv
// Shared constants, types and functions for the bounded xorwow generator.
// No dependencies; every other file uses this package by scoped names.
package xbr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned ADDR_W   = 2;

    localparam logic [WORD_W-1:0] WEYL_STEP = 32'd362437;

    localparam logic [ADDR_W-1:0] SEED_ADDR = 2'd0;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic reseed;
        logic step;
    } gen_ctrl_t;

    function automatic logic [WORD_W-1:0] cover_mask(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] xorwow_word(
        input logic [WORD_W-1:0] first,
        input logic [WORD_W-1:0] last
    );
        logic [WORD_W-1:0] t;
        t = last;
        t = t ^ (t >> 2);
        t = t ^ (t << 1);
        t = t ^ first ^ (first << 4);
        return t;
    endfunction

endpackage

FILE: rtl/xbr_if.sv
// Valid/ready stream interfaces for draw requests and drawn words.
// Depends on xbr_pkg for field widths.
interface xbr_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [xbr_pkg::WORD_W-1:0] range_limit;

    modport source (output valid, output cmd, output range_limit, input ready);
    modport sink   (input valid, input cmd, input range_limit, output ready);
endinterface

interface xbr_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [xbr_pkg::WORD_W-1:0] drawn_value;

    modport source (output valid, output drawn_value, input ready);
    modport sink   (input valid, input drawn_value, output ready);
endinterface

FILE: rtl/xbr_top.sv
// Bounded random draw block: request sequencer and output register.
// Depends on xbr_pkg, xbr_if, xbr_cfg and xbr_gen.
//
// Usage:
//   req carries cmd and range_limit; rsp carries drawn_value; both are
//   valid/ready channels, a word moves when valid and ready are high.
//   The APB port holds seed_word at byte address 0.
//   A reseed word loads seed_word into all five shift words, clears the
//   counter and returns nothing.
//   A draw word registers the limit and the cover mask of limit minus one
//   at acceptance, then steps the single xorshift-plus-add unit in the
//   rejection loop, once a cycle while the output register is free, and
//   compares the masked output to the limit. Fewer than two steps are
//   needed on average. The sequencer returns to IDLE as the result is
//   registered, so the next word can be taken from that point on.
//   A limit of 0 or 1 returns 0 without stepping.
//   req.ready is high while no draw is in progress, so the next word is
//   taken while a result still waits in the output register.
//   If rsp stalls, a draw in progress holds without stepping until the output
//   register frees.
//   Reset clears the seed, shift words and counter to zero and empties
//   the output register.
module xorwow_bounded_random (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xbr_pkg::ADDR_W-1:0] paddr,
    input  logic [xbr_pkg::WORD_W-1:0] pwdata,
    output logic [xbr_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    xbr_req_if.sink                    req,
    xbr_rsp_if.source                  rsp
);

    typedef enum logic {
        IDLE,
        DRAW
    } state_t;

    state_t                     state_reg;
    logic [xbr_pkg::WORD_W-1:0] limit_reg;
    logic [xbr_pkg::WORD_W-1:0] mask_reg;
    logic                       small_reg;
    logic                       rsp_valid_reg;
    logic [xbr_pkg::WORD_W-1:0] rsp_data_reg;

    logic [xbr_pkg::WORD_W-1:0] seed_word;
    logic [xbr_pkg::WORD_W-1:0] raw_next;
    logic [xbr_pkg::WORD_W-1:0] masked;
    xbr_pkg::gen_ctrl_t         gen_ctrl;
    logic                       req_fire;
    logic                       out_free;
    logic                       hit;
    logic                       done;

    xbr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .seed_word (seed_word)
    );

    xbr_gen u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (gen_ctrl),
        .seed_word (seed_word),
        .raw_next  (raw_next)
    );

    assign req.ready   = (state_reg == IDLE);
    assign req_fire    = req.valid && req.ready;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign masked      = raw_next & mask_reg;
    assign hit         = (masked < limit_reg);
    assign done        = (state_reg == DRAW) && out_free && (small_reg || hit);

    always_comb
    begin
        gen_ctrl.reseed = req_fire && (req.cmd == xbr_pkg::CMD_RESEED);
        gen_ctrl.step   = (state_reg == DRAW) && !small_reg && out_free;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.drawn_value = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (req_fire && (req.cmd == xbr_pkg::CMD_DRAW))
                    begin
                        state_reg <= DRAW;
                    end
                end
                DRAW:
                begin
                    if (done)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            limit_reg <= req.range_limit;
            mask_reg  <= xbr_pkg::cover_mask(req.range_limit - 32'd1);
            small_reg <= (req.range_limit < 32'd2);
        end
        if ((state_reg == DRAW) && out_free)
        begin
            if (small_reg)
            begin
                rsp_data_reg <= '0;
            end
            else if (hit)
            begin
                rsp_data_reg <= masked;
            end
        end
    end

endmodule

FILE: rtl/xbr_cfg.sv
// APB-style register port holding the seed word.
// Depends on xbr_pkg.
module xbr_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xbr_pkg::ADDR_W-1:0] paddr,
    input  logic [xbr_pkg::WORD_W-1:0] pwdata,
    output logic [xbr_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    output logic [xbr_pkg::WORD_W-1:0] seed_word
);

    logic [xbr_pkg::WORD_W-1:0] seed_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == xbr_pkg::SEED_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (wr_en)
        begin
            seed_reg <= pwdata;
        end
    end

    assign prdata    = (paddr == xbr_pkg::SEED_ADDR) ? seed_reg : '0;
    assign seed_word = seed_reg;

endmodule

FILE: rtl/xbr_gen.sv
// Xorwow state: five shift words, the Weyl counter and the one-step update unit.
// Depends on xbr_pkg.
module xbr_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  xbr_pkg::gen_ctrl_t         ctrl,
    input  logic [xbr_pkg::WORD_W-1:0] seed_word,
    output logic [xbr_pkg::WORD_W-1:0] raw_next
);

    logic [xbr_pkg::WORD_W-1:0] words_reg [xbr_pkg::NUM_WORDS];
    logic [xbr_pkg::WORD_W-1:0] weyl_reg;
    logic [xbr_pkg::WORD_W-1:0] first_next;
    logic [xbr_pkg::WORD_W-1:0] weyl_next;

    assign first_next = xbr_pkg::xorwow_word(words_reg[0], words_reg[xbr_pkg::NUM_WORDS-1]);
    assign weyl_next  = weyl_reg + xbr_pkg::WEYL_STEP;
    assign raw_next   = first_next + weyl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xbr_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
            weyl_reg <= '0;
        end
        else if (ctrl.reseed)
        begin
            for (int i = 0; i < xbr_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= seed_word;
            end
            weyl_reg <= '0;
        end
        else if (ctrl.step)
        begin
            for (int i = 1; i < xbr_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= words_reg[i-1];
            end
            words_reg[0] <= first_next;
            weyl_reg     <= weyl_next;
        end
    end

endmodule
